/* rtl/mpab_pkg.sv */
// ----------------------------------------------------------------------------
// mpab_pkg
// Shared types, constants and table addressing for the automaton builder.
// ----------------------------------------------------------------------------
package mpab_pkg;

    localparam int MAX_NODES = 4096;
    localparam int ALPHA     = 26;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int LET_W     = 5;
    localparam int TBL_DEPTH = MAX_NODES * ALPHA;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_BUILD  = 2'd2;
    localparam logic [1:0] ACT_LOOKUP = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNBUILT = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic              pattern_start;
        logic [LET_W-1:0]  letter;
        logic [NODE_W-1:0] from_node;
    } in_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [1:0]        status;
    } out_t;

    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [NODE_W-1:0] row,
                                                   input logic [LET_W-1:0] col);
        tbl_addr = TBL_AW'(row) * TBL_AW'(ALPHA) + TBL_AW'(col);
    endfunction

endpackage

/* rtl/mpab_ram.sv */
// ----------------------------------------------------------------------------
// mpab_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mpab_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/multi_pattern_automaton_builder_unit.sv */
// ----------------------------------------------------------------------------
// multi_pattern_automaton_builder_unit
// Aho-Corasick trie insert, automaton build and transition lookup.
// Lookup answers at once when unbuilt or out of range, else reads the goto table;
// insert of a new node clears its trie row before linking it; build fills row zero
// of the goto table, then walks the trie breadth-first setting fail links and goto rows.
// One beat at a time; busy stays high until the result strobe; no stall.
// After reset a pass clears trie row zero with busy high.
// ----------------------------------------------------------------------------
module multi_pattern_automaton_builder_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  mpab_pkg::in_t  cmd,
    output logic           busy,
    output logic           done,
    output mpab_pkg::out_t result
);
    import mpab_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_ICHK  = 4'd2;
    localparam logic [3:0] S_ILINK = 4'd3;
    localparam logic [3:0] S_LKRD  = 4'd4;
    localparam logic [3:0] S_R0RD  = 4'd5;
    localparam logic [3:0] S_R0WR  = 4'd6;
    localparam logic [3:0] S_POP   = 4'd7;
    localparam logic [3:0] S_U     = 4'd8;
    localparam logic [3:0] S_FU    = 4'd9;
    localparam logic [3:0] S_CRD   = 4'd10;
    localparam logic [3:0] S_CV    = 4'd11;
    localparam logic [3:0] S_FRD   = 4'd12;
    localparam logic [3:0] S_FSET  = 4'd13;
    localparam logic [3:0] S_KRD   = 4'd14;
    localparam logic [3:0] S_KWR   = 4'd15;

    localparam logic [LET_W-1:0] LAST_COL = LET_W'(ALPHA - 1);

    logic [3:0]        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic              pend_reg, pend_next;
    logic              built_reg, built_next;
    logic [NODE_W-1:0] nc_reg, nc_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] row_reg, row_next;
    logic [NODE_W-1:0] pre_reg, pre_next;
    logic [LET_W-1:0]  col_reg, col_next;
    logic [LET_W-1:0]  c_reg, c_next;
    logic [TBL_AW-1:0] slot_reg, slot_next;
    logic [NODE_W:0]   head_reg, head_next;
    logic [NODE_W:0]   tail_reg, tail_next;
    logic [NODE_W-1:0] u_reg, u_next;
    logic [NODE_W-1:0] fu_reg, fu_next;
    logic [NODE_W-1:0] v_reg, v_next;
    logic [NODE_W-1:0] f_reg, f_next;
    logic              done_reg, done_next;
    out_t              res_reg, res_next;

    logic              ch_we, go_we, fl_we, q_we;
    logic [TBL_AW-1:0] ch_waddr, ch_raddr, go_waddr, go_raddr;
    logic [NODE_W-1:0] ch_wdata, go_wdata, fl_wdata, q_wdata;
    logic [NODE_W-1:0] fl_waddr, fl_raddr, q_waddr, q_raddr;
    logic [NODE_W-1:0] ch_q, go_q, fl_q, q_q;
    logic              accept;
    logic [NODE_W-1:0] pre_sel;

    mpab_ram #(.DEPTH(TBL_DEPTH), .WIDTH(NODE_W)) u_child (
        .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr), .rdata(ch_q));
    mpab_ram #(.DEPTH(TBL_DEPTH), .WIDTH(NODE_W)) u_goto (
        .clk(clk), .we(go_we), .waddr(go_waddr), .wdata(go_wdata),
        .raddr(go_raddr), .rdata(go_q));
    mpab_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_fail (
        .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(fl_raddr), .rdata(fl_q));
    mpab_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_q));

    assign accept  = start && (state_reg == S_IDLE);
    assign pre_sel = cmd.pattern_start ? '0 : cur_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        pend_next  = pend_reg;
        built_next = built_reg;
        nc_next    = nc_reg;
        cur_next   = cur_reg;
        row_next   = row_reg;
        pre_next   = pre_reg;
        col_next   = col_reg;
        c_next     = c_reg;
        slot_next  = slot_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        u_next     = u_reg;
        fu_next    = fu_reg;
        v_next     = v_reg;
        f_next     = f_reg;
        done_next  = 1'b0;
        res_next   = res_reg;

        ch_we = 1'b0; ch_waddr = slot_reg; ch_wdata = '0; ch_raddr = slot_reg;
        go_we = 1'b0; go_waddr = tbl_addr(v_reg, col_reg); go_wdata = '0;
        go_raddr = tbl_addr(f_reg, col_reg);
        fl_we = 1'b0; fl_waddr = v_reg; fl_wdata = f_reg; fl_raddr = q_q;
        q_we = 1'b0; q_waddr = tail_reg[NODE_W-1:0]; q_wdata = v_reg;
        q_raddr = head_reg[NODE_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next = cmd.action;
                    unique case (cmd.action)
                        ACT_CLEAR:
                        begin
                            nc_next = '0; cur_next = '0; built_next = 1'b0;
                            row_next = '0; col_next = '0; pend_next = 1'b1;
                            state_next = S_CLR;
                        end
                        ACT_INSERT:
                        begin
                            if (cmd.letter >= LET_W'(ALPHA))
                            begin
                                done_next = 1'b1;
                                res_next = '{node: cur_reg, status: ST_OK};
                            end
                            else
                            begin
                                pre_next   = pre_sel;
                                slot_next  = tbl_addr(pre_sel, cmd.letter);
                                ch_raddr   = tbl_addr(pre_sel, cmd.letter);
                                state_next = S_ICHK;
                            end
                        end
                        ACT_BUILD:
                        begin
                            fl_we = 1'b1; fl_waddr = '0; fl_wdata = '0;
                            q_we = 1'b1; q_waddr = '0; q_wdata = '0;
                            head_next = '0; tail_next = (NODE_W+1)'(1);
                            col_next = '0; state_next = S_R0RD;
                        end
                        ACT_LOOKUP:
                        begin
                            if (!built_reg)
                            begin
                                done_next = 1'b1;
                                res_next = '{node: '0, status: ST_UNBUILT};
                            end
                            else if (cmd.letter >= LET_W'(ALPHA) || cmd.from_node > nc_reg)
                            begin
                                done_next = 1'b1;
                                res_next = '{node: '0, status: ST_OK};
                            end
                            else
                            begin
                                go_raddr = tbl_addr(cmd.from_node, cmd.letter);
                                state_next = S_LKRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR:
            begin
                ch_we = 1'b1; ch_waddr = tbl_addr(row_reg, col_reg); ch_wdata = '0;
                col_next = col_reg + 1'b1;
                if (col_reg == LAST_COL)
                begin
                    if (op_reg == ACT_INSERT)
                    begin
                        state_next = S_ILINK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        done_next  = pend_reg;
                        res_next   = '{node: '0, status: ST_OK};
                    end
                end
            end
            S_ICHK:
            begin
                if (ch_q != '0)
                begin
                    cur_next = ch_q; done_next = 1'b1; state_next = S_IDLE;
                    res_next = '{node: ch_q, status: ST_OK};
                end
                else if ({1'b0, nc_reg} + 1'b1 >= (NODE_W+1)'(MAX_NODES))
                begin
                    cur_next = pre_reg; done_next = 1'b1; state_next = S_IDLE;
                    res_next = '{node: pre_reg, status: ST_FULL};
                end
                else
                begin
                    nc_next = nc_reg + 1'b1; cur_next = nc_reg + 1'b1;
                    row_next = nc_reg + 1'b1; col_next = '0;
                    built_next = 1'b0; state_next = S_CLR;
                end
            end
            S_ILINK:
            begin
                ch_we = 1'b1; ch_waddr = slot_reg; ch_wdata = nc_reg;
                done_next = 1'b1; state_next = S_IDLE;
                res_next = '{node: nc_reg, status: ST_OK};
            end
            S_LKRD:
            begin
                done_next = 1'b1; state_next = S_IDLE;
                res_next = '{node: go_q, status: ST_OK};
            end
            S_R0RD:
            begin
                ch_raddr = tbl_addr('0, col_reg);
                state_next = S_R0WR;
            end
            S_R0WR:
            begin
                go_we = 1'b1; go_waddr = tbl_addr('0, col_reg); go_wdata = ch_q;
                col_next = col_reg + 1'b1;
                state_next = (col_reg == LAST_COL) ? S_POP : S_R0RD;
            end
            S_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    built_next = 1'b1; done_next = 1'b1; state_next = S_IDLE;
                    res_next = '{node: nc_reg, status: ST_OK};
                end
                else
                begin
                    head_next = head_reg + 1'b1;
                    state_next = S_U;
                end
            end
            S_U:
            begin
                u_next = q_q; fl_raddr = q_q;
                state_next = S_FU;
            end
            S_FU:
            begin
                fu_next = fl_q; c_next = '0;
                state_next = S_CRD;
            end
            S_CRD:
            begin
                ch_raddr = tbl_addr(u_reg, c_reg);
                state_next = S_CV;
            end
            S_CV:
            begin
                if (ch_q == '0 || ch_q > nc_reg || tail_reg >= (NODE_W+1)'(MAX_NODES))
                begin
                    c_next = c_reg + 1'b1;
                    state_next = (c_reg == LAST_COL) ? S_POP : S_CRD;
                end
                else
                begin
                    v_next = ch_q;
                    if (u_reg == '0)
                    begin
                        f_next = '0; state_next = S_FSET;
                    end
                    else
                    begin
                        go_raddr = tbl_addr(fu_reg, c_reg);
                        state_next = S_FRD;
                    end
                end
            end
            S_FRD:
            begin
                f_next = (go_q > nc_reg) ? '0 : go_q;
                state_next = S_FSET;
            end
            S_FSET:
            begin
                fl_we = 1'b1; fl_waddr = v_reg; fl_wdata = f_reg;
                q_we = 1'b1; q_waddr = tail_reg[NODE_W-1:0]; q_wdata = v_reg;
                tail_next = tail_reg + 1'b1;
                col_next = '0; state_next = S_KRD;
            end
            S_KRD:
            begin
                ch_raddr = tbl_addr(v_reg, col_reg);
                go_raddr = tbl_addr(f_reg, col_reg);
                state_next = S_KWR;
            end
            S_KWR:
            begin
                go_we = 1'b1; go_waddr = tbl_addr(v_reg, col_reg);
                go_wdata = (ch_q != '0) ? ch_q : go_q;
                col_next = col_reg + 1'b1;
                if (col_reg == LAST_COL)
                begin
                    c_next = c_reg + 1'b1;
                    state_next = (c_reg == LAST_COL) ? S_POP : S_CRD;
                end
                else
                begin
                    state_next = S_KRD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            op_reg    <= ACT_CLEAR;
            pend_reg  <= 1'b0;
            built_reg <= 1'b0;
            nc_reg    <= '0;
            cur_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            pend_reg  <= pend_next;
            built_reg <= built_next;
            nc_reg    <= nc_next;
            cur_reg   <= cur_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_reg  <= pre_next;
        c_reg    <= c_next;
        slot_reg <= slot_next;
        u_reg    <= u_next;
        fu_reg   <= fu_next;
        v_reg    <= v_next;
        f_reg    <= f_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result strobe while busy");
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> nc_reg == NODE_W'(MAX_NODES - 1))
        else $error("store full flagged below capacity");
    a_unbuilt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_UNBUILT) |-> result.node == '0)
        else $error("unbuilt lookup returned a node");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_FULL ||
                  result.status == ST_UNBUILT)) else $error("bad status");

endmodule

/* tb/sv/multi_pattern_automaton_builder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_automaton_builder_unit_tb
// Drives clear, insert, build and lookup beats into the automaton builder,
// mirrors the trie, failure links and goto table in a local model, and checks
// each result beat in order. Covers lookups before build, out-of-range letters
// and nodes, then random pattern sets with random gaps.
// ----------------------------------------------------------------------------
module multi_pattern_automaton_builder_unit_tb;
    import mpab_pkg::*;

    localparam int IDLE_PCT  = 27;
    localparam int WD_LIMIT  = 200000;
    localparam int RAND_BEATS = 1250;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t  cmd = '0;
    logic busy;
    logic done;
    out_t result;

    multi_pattern_automaton_builder_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    // trie mirror
    logic [NODE_W-1:0] m_child [0:TBL_DEPTH-1];
    logic [NODE_W-1:0] m_goto  [0:TBL_DEPTH-1];
    logic [NODE_W-1:0] m_fail  [0:MAX_NODES-1];
    logic [NODE_W-1:0] m_bfs   [0:MAX_NODES-1];
    int unsigned       m_count;
    int unsigned       m_cursor;
    bit                m_built;

    in_t  cmd_beats[$];
    out_t expected_beats[$];
    int   n_sent = 0;
    int   n_done = 0;
    int   n_total = 0;
    int   errors = 0;
    int   pause_at = 600;
    int   wd_count = 0;

    function automatic int idx(int unsigned row, int unsigned col);
        return row * ALPHA + col;
    endfunction

    function automatic void build_links();
        int unsigned head, tail, u, v, f, ch;
        head = 0;
        tail = 0;
        m_fail[0] = '0;
        for (int c = 0; c < ALPHA; c++)
            m_goto[idx(0, c)] = m_child[idx(0, c)];
        m_bfs[tail] = '0;
        tail++;
        while (head < tail)
        begin
            u = 32'(m_bfs[head]);
            head++;
            for (int c = 0; c < ALPHA; c++)
            begin
                v = 32'(m_child[idx(u, c)]);
                if (v == 0 || v > m_count || tail >= MAX_NODES)
                    continue;
                f = (u == 0) ? 0 : 32'(m_goto[idx(32'(m_fail[u]), c)]);
                if (f > m_count)
                    f = 0;
                m_fail[v] = NODE_W'(f);
                for (int k = 0; k < ALPHA; k++)
                begin
                    ch = 32'(m_child[idx(v, k)]);
                    m_goto[idx(v, k)] = (ch != 0) ? NODE_W'(ch) : m_goto[idx(f, k)];
                end
                m_bfs[tail] = NODE_W'(v);
                tail++;
            end
        end
        m_built = 1'b1;
    endfunction

    function automatic out_t automaton_step(in_t c);
        out_t r;
        int unsigned pre, nxt;
        r = '0;
        case (c.action)
            ACT_CLEAR:
            begin
                m_count = 0;
                m_cursor = 0;
                m_built = 1'b0;
                for (int k = 0; k < ALPHA; k++)
                    m_child[idx(0, k)] = '0;
            end
            ACT_INSERT:
            begin
                if (c.letter < ALPHA)
                begin
                    pre = c.pattern_start ? 0 : m_cursor;
                    nxt = 32'(m_child[idx(pre, 32'(c.letter))]);
                    if (nxt != 0)
                    begin
                        m_cursor = nxt;
                    end
                    else if (m_count + 1 >= MAX_NODES)
                    begin
                        m_cursor = pre;
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        m_count++;
                        for (int k = 0; k < ALPHA; k++)
                            m_child[idx(m_count, k)] = '0;
                        m_child[idx(pre, 32'(c.letter))] = NODE_W'(m_count);
                        m_cursor = m_count;
                        m_built = 1'b0;
                    end
                end
                r.node = NODE_W'(m_cursor);
            end
            ACT_BUILD:
            begin
                build_links();
                r.node = NODE_W'(m_count);
            end
            default:
            begin
                if (!m_built)
                    r.status = ST_UNBUILT;
                else if (c.letter < ALPHA && c.from_node <= m_count)
                    r.node = m_goto[idx(32'(c.from_node), 32'(c.letter))];
            end
        endcase
        return r;
    endfunction

    task automatic add(logic [1:0] act, int unsigned ps, int unsigned ltr,
                       int unsigned from);
        in_t c;
        c.action = act;
        c.pattern_start = ps[0];
        c.letter = LET_W'(ltr);
        c.from_node = NODE_W'(from);
        cmd_beats.push_back(c);
        expected_beats.push_back(automaton_step(c));
        n_total++;
    endtask

    task automatic report(string what, int unsigned got, int unsigned want);
        errors++;
        $display("mismatch beat %0d %s: got %0d want %0d", n_done, what, got, want);
    endtask

    // driver
    always @(posedge clk)
    begin
        logic fire;
        int   idle;
        fire = start && !busy;
        if (fire)
            n_sent++;
        idle = (n_sent >= 300 && n_sent < 700) ? 0 : IDLE_PCT;
        if (rst_n && (!start || fire))
        begin
            if (cmd_beats.size() > 0 && !(n_sent == pause_at && n_done < n_sent)
                && $urandom_range(99) >= idle)
            begin
                start <= 1'b1;
                cmd   <= cmd_beats.pop_front();
            end
            else
            begin
                start <= 1'b0;
                cmd   <= $bits(in_t)'($urandom);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_t w;
        if (rst_n && done)
        begin
            if (expected_beats.size() == 0)
            begin
                report("unexpected", 32'(result.node), 0);
            end
            else
            begin
                w = expected_beats.pop_front();
                if (result.node !== w.node)
                    report("node", 32'(result.node), 32'(w.node));
                if (result.status !== w.status)
                    report("status", 32'(result.status), 32'(w.status));
            end
            n_done++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT)
        begin
            $display("multi_pattern_automaton_builder_unit_tb failed");
            $finish;
        end
    end

    initial
    begin
        int npat, plen, span;
        for (int k = 0; k < ALPHA; k++)
            m_child[k] = '0;
        m_count = 0;
        m_cursor = 0;
        m_built = 1'b0;

        // directed
        add(ACT_LOOKUP, 0, 0, 0);
        add(ACT_INSERT, 1, 31, 4095);
        add(ACT_INSERT, 1, 0, 0);
        add(ACT_INSERT, 0, 25, 0);
        add(ACT_INSERT, 1, 25, 0);
        add(ACT_INSERT, 0, 0, 0);
        add(ACT_INSERT, 1, 0, 0);
        add(ACT_INSERT, 0, 26, 0);
        add(ACT_BUILD, 1, 31, 4095);
        add(ACT_LOOKUP, 0, 0, 0);
        add(ACT_LOOKUP, 0, 25, 2);
        add(ACT_LOOKUP, 1, 0, 4);
        add(ACT_LOOKUP, 0, 0, 4095);
        add(ACT_LOOKUP, 0, 31, 1);
        add(ACT_INSERT, 1, 1, 0);
        add(ACT_LOOKUP, 0, 0, 1);
        add(ACT_CLEAR, 1, 31, 4095);
        add(ACT_LOOKUP, 0, 0, 0);
        add(ACT_BUILD, 0, 0, 0);
        add(ACT_LOOKUP, 0, 25, 0);

        // random pattern sets
        while (n_total < RAND_BEATS)
        begin
            add(ACT_CLEAR, $urandom, $urandom, $urandom);
            npat = $urandom_range(1, 8);
            span = ($urandom_range(1) == 1) ? 3 : 25;
            for (int p = 0; p < npat; p++)
            begin
                plen = $urandom_range(1, 6);
                for (int j = 0; j < plen; j++)
                begin
                    if ($urandom_range(19) == 0)
                        add(ACT_INSERT, $urandom, $urandom_range(26, 31), $urandom);
                    else
                        add(ACT_INSERT, (j == 0) ? 1 : 0, $urandom_range(span), $urandom);
                end
            end
            if ($urandom_range(3) == 0)
                add(ACT_LOOKUP, $urandom, $urandom, $urandom);
            add(ACT_BUILD, $urandom, $urandom, $urandom);
            for (int j = $urandom_range(10, 30); j > 0; j--)
            begin
                case ($urandom_range(19))
                    0: add(ACT_LOOKUP, $urandom, $urandom, $urandom);
                    1: add(ACT_INSERT, $urandom, $urandom_range(span), 0);
                    2: add(ACT_BUILD, $urandom, $urandom, $urandom);
                    default: add(ACT_LOOKUP, $urandom, $urandom_range(span),
                                 $urandom_range(m_count));
                endcase
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait (cmd_beats.size() == 0 && n_done == n_total);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_beats.size() == 0)
            $display("multi_pattern_automaton_builder_unit_tb passed");
        else
            $display("multi_pattern_automaton_builder_unit_tb failed");
        $finish;
    end
endmodule
